// ===== rtl/tid_range_port_selector_defines.svh =====
// assertion helpers
`ifndef TID_RANGE_PORT_SELECTOR_DEFINES_SVH
`define TID_RANGE_PORT_SELECTOR_DEFINES_SVH
`define TRPS_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TRPS_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`endif

// ===== rtl/trps_pkg.sv =====
`default_nettype none
package trps_pkg;
    localparam int PORTS = 16;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_ACTIVE = 2'd3;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_OVERLAP  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_FALLBACK = 3'd4;
    localparam logic [2:0] ST_NOPORT   = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    localparam logic [0:0] REG_PC_WILDCARD  = 1'd0;
    localparam logic [0:0] REG_SSN_WILDCARD = 1'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  port;
        logic [31:0] point_code;
        logic [7:0]  subsystem;
        logic [31:0] tid_first;
        logic [31:0] tid_last;
        logic        active;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] chosen_port;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  port;
        logic [31:0] pc;
        logic [7:0]  ssn;
        logic [31:0] first;
        logic [31:0] last;
    } entry_t;
endpackage
`default_nettype wire

// ===== rtl/trps_ram.sv =====
`default_nettype none
module trps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/tid_range_port_selector.sv =====
// tid range port selector
// in channel (in_valid/in_ready, in_data) carries one command transfer:
// add range, lookup, remove port or set port active. out channel
// (out_valid/out_ready, out_data) returns one status transfer per command.
// range fields live in a single-port-read ram, walked one slot a cycle.
// add: one sweep (free slot and overlap scan), then the decision and the write.
// lookup: up to four probe sweeps, each passed over when gated off, then a
// round-robin fallback search over up to PORTS ports.
// remove: two sweeps (free the port's slots, then recompute the flags), then
// the answer; a remove of a port that is not enabled and set active skip the
// sweeps and go to the answer. one command is in work at a time.
// reset clears the valid bits, flags, port masks and round-robin pointer
// at once; no clearing pass is needed. the apb port writes pc_wildcard
// (address 0) and ssn_wildcard (address 4) and reads them back.
// the result moves into the output register once that is empty or drains, and
// waits there; the next command is accepted while it waits, but its own result is held
// until out_ready drains it.
`default_nettype none
`include "tid_range_port_selector_defines.svh"
module tid_range_port_selector #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire trps_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output trps_pkg::out_item_t     out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(trps_pkg::PORTS);
    localparam int CW = $clog2(TABLE_ENTRIES + 2);

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_LOOK, S_RR, S_REM, S_FLAG, S_OUT
    } state_t;

    state_t                 state_reg;
    trps_pkg::in_item_t     cmd_reg;
    logic [CW-1:0]          cnt_reg;
    logic [1:0]             probe_reg;
    logic                   found_reg;
    logic [AW-1:0]          slot_reg;
    logic                   ovl_reg;
    logic                   fpc_reg;
    logic                   fssn_reg;
    logic [PW-1:0]          rr_reg;
    logic [PW-1:0]          rr_first_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                   spc_reg;
    logic                   sssn_reg;
    logic [trps_pkg::PORTS-1:0] en_reg;
    logic [trps_pkg::PORTS-1:0] act_reg;
    logic [PW-1:0]          last_reg;
    logic [31:0]            pcw_reg;
    logic [7:0]             ssnw_reg;
    trps_pkg::out_item_t    res_reg;
    logic                   res_pend_reg;
    logic                   out_valid_reg;
    trps_pkg::out_item_t    out_reg;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    trps_pkg::entry_t ram_wdata;
    trps_pkg::entry_t rd;

    trps_ram #(.WIDTH($bits(trps_pkg::entry_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    // data of slot cnt_reg-1 is on rd while cnt_reg > 0
    logic [AW-1:0] cur;
    logic          cur_v;
    logic          sweep_end;
    logic [31:0]   key_pc;
    logic [7:0]    key_ssn;
    logic          probe_ok;
    logic          port_ok;
    logic          cfg_wr;

    assign ram_raddr = cnt_reg[AW-1:0];
    assign cur       = AW'(cnt_reg - CW'(1));
    assign cur_v     = (cnt_reg != '0) && valid_reg[cur];
    assign sweep_end = (cnt_reg == CW'(TABLE_ENTRIES));
    assign port_ok   = (32'(cmd_reg.port) < 32'(trps_pkg::PORTS));
    assign ram_wdata = '{port: cmd_reg.port, pc: cmd_reg.point_code,
                         ssn: cmd_reg.subsystem, first: cmd_reg.tid_first,
                         last: cmd_reg.tid_last};
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !res_pend_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        key_pc   = cmd_reg.point_code;
        key_ssn  = cmd_reg.subsystem;
        probe_ok = 1'b1;
        case (probe_reg)
            2'd0:
            begin
                probe_ok = spc_reg && sssn_reg;
            end
            2'd1:
            begin
                key_pc   = pcw_reg;
                probe_ok = sssn_reg;
            end
            2'd2:
            begin
                key_ssn  = ssnw_reg;
                probe_ok = spc_reg;
            end
            default:
            begin
                key_pc  = pcw_reg;
                key_ssn = ssnw_reg;
            end
        endcase
    end

    always_comb
    begin
        case (paddr[2])
            trps_pkg::REG_PC_WILDCARD:  prdata = pcw_reg;
            default:                    prdata = {24'd0, ssnw_reg};
        endcase
    end

    assign ram_we = (state_reg == S_ADD) && (cnt_reg == CW'(TABLE_ENTRIES + 1)) &&
                    !ovl_reg && port_ok && found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            spc_reg       <= 1'b0;
            sssn_reg      <= 1'b0;
            en_reg        <= '0;
            act_reg       <= '0;
            last_reg      <= '0;
            pcw_reg       <= 32'hFFFF_FFFF;
            ssnw_reg      <= 8'd0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            probe_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[2])
                    trps_pkg::REG_PC_WILDCARD:  pcw_reg  <= pwdata;
                    default:                    ssnw_reg <= pwdata[7:0];
                endcase
            end
            if (res_pend_reg && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res_reg;
                res_pend_reg  <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        cmd_reg   <= in_data;
                        cnt_reg   <= '0;
                        probe_reg <= '0;
                        found_reg <= 1'b0;
                        ovl_reg   <= 1'b0;
                        fpc_reg   <= 1'b0;
                        fssn_reg  <= 1'b0;
                        case (in_data.kind)
                            trps_pkg::KIND_ADD:    state_reg <= S_ADD;
                            trps_pkg::KIND_LOOKUP: state_reg <= S_LOOK;
                            trps_pkg::KIND_REMOVE: state_reg <= S_REM;
                            default:               state_reg <= S_OUT;
                        endcase
                    end
                end
                S_ADD:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg != '0 && cnt_reg <= CW'(TABLE_ENTRIES))
                    begin
                        if (!valid_reg[cur])
                        begin
                            if (!found_reg)
                            begin
                                found_reg <= 1'b1;
                                slot_reg  <= cur;
                            end
                        end
                        else if (rd.pc == cmd_reg.point_code && rd.ssn == cmd_reg.subsystem &&
                                 ((rd.first >= cmd_reg.tid_first && rd.first <= cmd_reg.tid_last) ||
                                  (rd.last >= cmd_reg.tid_first && rd.last <= cmd_reg.tid_last) ||
                                  (cmd_reg.tid_first >= rd.first && cmd_reg.tid_first <= rd.last) ||
                                  (cmd_reg.tid_last >= rd.first && cmd_reg.tid_last <= rd.last)))
                        begin
                            ovl_reg <= 1'b1;
                        end
                    end
                    // overlap may still be raised by the last slot: decide in the cycle after it
                    if (cnt_reg == CW'(TABLE_ENTRIES + 1))
                    begin
                        res_reg.chosen_port <= '0;
                        if (ovl_reg)
                        begin
                            res_reg.status <= trps_pkg::ST_OVERLAP;
                        end
                        else if (!port_ok || !found_reg)
                        begin
                            res_reg.status <= trps_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_reg.status <= trps_pkg::ST_ADDED;
                            valid_reg[slot_reg] <= 1'b1;
                            en_reg[cmd_reg.port[PW-1:0]] <= 1'b1;
                            if (cmd_reg.point_code != pcw_reg)
                            begin
                                spc_reg <= 1'b1;
                            end
                            if (cmd_reg.subsystem != ssnw_reg)
                            begin
                                sssn_reg <= 1'b1;
                            end
                        end
                        res_pend_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_LOOK:
                begin
                    if (!probe_ok)
                    begin
                        probe_reg <= probe_reg + 2'd1;
                        cnt_reg   <= '0;
                        if (probe_reg == 2'd3)
                        begin
                            state_reg <= S_RR;
                        end
                    end
                    else if (cur_v && rd.pc == key_pc && rd.ssn == key_ssn &&
                             cmd_reg.tid_first >= rd.first && cmd_reg.tid_first <= rd.last)
                    begin
                        res_reg.status      <= trps_pkg::ST_RANGE;
                        res_reg.chosen_port <= rd.port;
                        res_pend_reg        <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                    else if (sweep_end)
                    begin
                        cnt_reg   <= '0;
                        probe_reg <= probe_reg + 2'd1;
                        if (probe_reg == 2'd3)
                        begin
                            state_reg    <= S_RR;
                            rr_reg       <= PW'((32'(last_reg) + 1) % trps_pkg::PORTS);
                            rr_first_reg <= PW'((32'(last_reg) + 1) % trps_pkg::PORTS);
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (!probe_ok && probe_reg == 2'd3)
                    begin
                        rr_reg       <= PW'((32'(last_reg) + 1) % trps_pkg::PORTS);
                        rr_first_reg <= PW'((32'(last_reg) + 1) % trps_pkg::PORTS);
                    end
                end
                S_RR:
                begin
                    if (act_reg[rr_reg] && en_reg[rr_reg])
                    begin
                        last_reg            <= rr_reg;
                        res_reg.status      <= trps_pkg::ST_FALLBACK;
                        res_reg.chosen_port <= 4'(rr_reg);
                        res_pend_reg        <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                    else if (PW'((32'(rr_reg) + 1) % trps_pkg::PORTS) == rr_first_reg)
                    begin
                        last_reg            <= rr_first_reg;
                        res_reg.status      <= trps_pkg::ST_NOPORT;
                        res_reg.chosen_port <= '0;
                        res_pend_reg        <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                    else
                    begin
                        rr_reg <= PW'((32'(rr_reg) + 1) % trps_pkg::PORTS);
                    end
                end
                S_REM:
                begin
                    if (!port_ok || !en_reg[cmd_reg.port[PW-1:0]])
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (cur_v && rd.port == cmd_reg.port)
                        begin
                            valid_reg[cur] <= 1'b0;
                        end
                        if (sweep_end)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_FLAG;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                end
                S_FLAG:
                begin
                    if (cur_v && rd.pc != pcw_reg)
                    begin
                        fpc_reg <= 1'b1;
                    end
                    if (cur_v && rd.ssn != ssnw_reg)
                    begin
                        fssn_reg <= 1'b1;
                    end
                    if (sweep_end)
                    begin
                        spc_reg  <= spc_reg && (fpc_reg || (cur_v && rd.pc != pcw_reg));
                        sssn_reg <= sssn_reg && (fssn_reg || (cur_v && rd.ssn != ssnw_reg));
                        en_reg[cmd_reg.port[PW-1:0]]  <= 1'b0;
                        act_reg[cmd_reg.port[PW-1:0]] <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_OUT:
                begin
                    if (cmd_reg.kind == trps_pkg::KIND_ACTIVE && port_ok)
                    begin
                        act_reg[cmd_reg.port[PW-1:0]] <= cmd_reg.active;
                    end
                    if (cmd_reg.kind == trps_pkg::KIND_ADD)
                    begin
                        state_reg <= S_ADD;
                    end
                    else
                    begin
                        res_reg.status      <= trps_pkg::ST_DONE;
                        res_reg.chosen_port <= '0;
                        res_pend_reg        <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TRPS_ASSERT_IMPL(a_no_accept_busy, clk, rst_n,
        (in_valid && in_ready) |-> (state_reg == S_IDLE))
    `TRPS_ASSERT_NEXT(a_out_holds, clk, rst_n, (out_valid && !out_ready),
        (out_valid && $stable(out_data)))
    `TRPS_ASSERT_IMPL(a_rr_in_range, clk, rst_n,
        (state_reg == S_RR) |-> (32'(rr_reg) < 32'(trps_pkg::PORTS)))
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int SLOTS = 64;
    localparam int NPORTS = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    trps_pkg::in_item_t in_data;
    logic out_valid;
    logic out_ready;
    trps_pkg::out_item_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    tid_range_port_selector i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // selector shadow state
    logic [31:0] sh_pc_wild;
    logic [7:0]  sh_ssn_wild;
    logic        sh_valid [SLOTS];
    trps_pkg::entry_t sh_entry [SLOTS];
    logic        sh_spec_pc;
    logic        sh_spec_ssn;
    logic [15:0] sh_enabled;
    logic [15:0] sh_active;
    logic [3:0]  sh_last_port;

    trps_pkg::out_item_t status_queue[$];
    int mismatches;
    int received;
    int lookups_by_range;
    int lookups_fallback;
    longint cycle_count;
    logic quiet;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tid_range_port_selector verification failed");
            $finish;
        end
    end

    function automatic int find_slot(logic [31:0] pc, logic [7:0] ssn, logic [31:0] tid);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sh_valid[i] && sh_entry[i].pc == pc && sh_entry[i].ssn == ssn &&
                tid >= sh_entry[i].first && tid <= sh_entry[i].last)
                return i;
        end
        return -1;
    endfunction

    function automatic bit spans(logic [31:0] lo, logic [31:0] hi, logic [31:0] v);
        return v >= lo && v <= hi;
    endfunction

    function automatic trps_pkg::out_item_t select_port(trps_pkg::in_item_t it);
        trps_pkg::out_item_t r;
        int freeslot;
        bit ovl;
        int hit;
        logic [3:0] first;
        logic [3:0] p;
        bit found;
        bit fpc;
        bit fssn;
        r.status = trps_pkg::ST_DONE;
        r.chosen_port = '0;
        case (it.kind)
            trps_pkg::KIND_ADD:
            begin
                freeslot = -1;
                ovl = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!sh_valid[i])
                    begin
                        if (freeslot < 0)
                            freeslot = i;
                    end
                    else if (sh_entry[i].pc == it.point_code && sh_entry[i].ssn == it.subsystem)
                    begin
                        if (spans(it.tid_first, it.tid_last, sh_entry[i].first) ||
                            spans(it.tid_first, it.tid_last, sh_entry[i].last) ||
                            spans(sh_entry[i].first, sh_entry[i].last, it.tid_first) ||
                            spans(sh_entry[i].first, sh_entry[i].last, it.tid_last))
                            ovl = 1;
                    end
                end
                if (ovl)
                    r.status = trps_pkg::ST_OVERLAP;
                else if (freeslot < 0)
                    r.status = trps_pkg::ST_FULL;
                else
                begin
                    sh_valid[freeslot] = 1'b1;
                    sh_entry[freeslot] = '{it.port, it.point_code, it.subsystem,
                                           it.tid_first, it.tid_last};
                    if (it.point_code != sh_pc_wild)
                        sh_spec_pc = 1'b1;
                    if (it.subsystem != sh_ssn_wild)
                        sh_spec_ssn = 1'b1;
                    sh_enabled[it.port] = 1'b1;
                    r.status = trps_pkg::ST_ADDED;
                end
            end
            trps_pkg::KIND_LOOKUP:
            begin
                hit = -1;
                if (sh_spec_pc && sh_spec_ssn)
                    hit = find_slot(it.point_code, it.subsystem, it.tid_first);
                if (hit < 0 && sh_spec_ssn)
                    hit = find_slot(sh_pc_wild, it.subsystem, it.tid_first);
                if (hit < 0 && sh_spec_pc)
                    hit = find_slot(it.point_code, sh_ssn_wild, it.tid_first);
                if (hit < 0)
                    hit = find_slot(sh_pc_wild, sh_ssn_wild, it.tid_first);
                if (hit >= 0)
                begin
                    r.status = trps_pkg::ST_RANGE;
                    r.chosen_port = sh_entry[hit].port;
                end
                else
                begin
                    first = sh_last_port + 4'd1;
                    p = first;
                    found = 0;
                    do
                    begin
                        if (sh_active[p] && sh_enabled[p])
                        begin
                            found = 1;
                            break;
                        end
                        p = p + 4'd1;
                    end while (p != first);
                    sh_last_port = p;
                    if (found)
                    begin
                        r.status = trps_pkg::ST_FALLBACK;
                        r.chosen_port = p;
                    end
                    else
                        r.status = trps_pkg::ST_NOPORT;
                end
            end
            trps_pkg::KIND_REMOVE:
            begin
                if (sh_enabled[it.port])
                begin
                    fpc = 0;
                    fssn = 0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (sh_valid[i] && sh_entry[i].port == it.port)
                            sh_valid[i] = 1'b0;
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (sh_valid[i])
                        begin
                            if (sh_entry[i].pc != sh_pc_wild)
                                fpc = 1;
                            if (sh_entry[i].ssn != sh_ssn_wild)
                                fssn = 1;
                        end
                    end
                    sh_spec_pc = sh_spec_pc && fpc;
                    sh_spec_ssn = sh_spec_ssn && fssn;
                    sh_enabled[it.port] = 1'b0;
                    sh_active[it.port] = 1'b0;
                end
            end
            default:
                sh_active[it.port] = it.active;
        endcase
        return r;
    endfunction

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        trps_pkg::out_item_t exp_item;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                received <= received + 1;
                if (status_queue.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result transfer %p", out_data);
                end
                else
                begin
                    exp_item = status_queue.pop_front();
                    if (exp_item.status == trps_pkg::ST_RANGE)
                        lookups_by_range <= lookups_by_range + 1;
                    if (exp_item.status == trps_pkg::ST_FALLBACK)
                        lookups_fallback <= lookups_fallback + 1;
                    if (out_data.status !== exp_item.status ||
                        out_data.chosen_port !== exp_item.chosen_port)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected status %0d port %0d, got %0d port %0d",
                                     exp_item.status, exp_item.chosen_port,
                                     out_data.status, out_data.chosen_port);
                    end
                end
            end
            out_ready <= quiet || ($urandom_range(99) >= 22);
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'd0)
            sh_pc_wild = value;
        else
            sh_ssn_wild = value[7:0];
        @(posedge clk);
    endtask

    task automatic drain();
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (8 * SLOTS) @(posedge clk);
    endtask

    // one command transfer; a typed-in expected result is checked against the prediction when check_fixed is set
    task automatic send_cmd(trps_pkg::in_item_t it, bit check_fixed,
                            trps_pkg::out_item_t fixed);
        trps_pkg::out_item_t pred;
        while (!quiet && $urandom_range(99) < 22)
            @(posedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        pred = select_port(it);
        if (check_fixed && pred != fixed)
        begin
            if (mismatches < 10)
                $display("table row disagrees with prediction: %p vs %p", fixed, pred);
            mismatches = mismatches + 1;
        end
        status_queue.push_back(pred);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic trps_pkg::in_item_t mk(logic [1:0] k, logic [3:0] p, logic [31:0] pc,
                                              logic [7:0] ssn, logic [31:0] t0,
                                              logic [31:0] t1, logic a);
        trps_pkg::in_item_t it;
        it = '{k, p, pc, ssn, t0, t1, a};
        return it;
    endfunction

    typedef struct {
        trps_pkg::in_item_t   cmd;
        bit                   fixed;
        trps_pkg::out_item_t  res;
    } row_t;

    function automatic trps_pkg::in_item_t rand_item(bit well_formed);
        trps_pkg::in_item_t it;
        logic [31:0] base;
        it.kind = $urandom_range(3);
        it.port = $urandom_range(15);
        it.point_code = ($urandom_range(3) == 0) ? $urandom :
                        (($urandom_range(2) == 0) ? sh_pc_wild : 32'(100 + $urandom_range(2)));
        it.subsystem = ($urandom_range(3) == 0) ? 8'($urandom) :
                       (($urandom_range(2) == 0) ? sh_ssn_wild : 8'(7 + $urandom_range(1)));
        base = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(40) * 1000);
        it.tid_first = base + $urandom_range(999);
        it.tid_last = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(999);
        it.active = $urandom_range(1);
        if (well_formed && it.kind == trps_pkg::KIND_REMOVE && $urandom_range(2) != 0)
            it.kind = trps_pkg::KIND_LOOKUP;
        return it;
    endfunction

    initial
    begin
        row_t rows[$];
        trps_pkg::out_item_t nil;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        mismatches = 0;
        received = 0;
        lookups_by_range = 0;
        lookups_fallback = 0;
        cycle_count = 0;
        sh_pc_wild = 32'hFFFF_FFFF;
        sh_ssn_wild = 8'h00;
        for (int i = 0; i < SLOTS; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_entry[i] = '0;
        end
        sh_spec_pc = 1'b0;
        sh_spec_ssn = 1'b0;
        sh_enabled = '0;
        sh_active = '0;
        sh_last_port = '0;
        nil = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{mk(trps_pkg::KIND_LOOKUP, 4'd0, 32'd5, 8'd1, 32'd0, 32'd0, 1'b0), 1,
                        '{trps_pkg::ST_NOPORT, 4'd0}});
        rows.push_back('{mk(trps_pkg::KIND_REMOVE, 4'd3, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0), 1,
                        '{trps_pkg::ST_DONE, 4'd0}});
        rows.push_back('{mk(trps_pkg::KIND_ADD, 4'd15, 32'hFFFF_FFFF, 8'h00, 32'd0,
                            32'hFFFF_FFFF, 1'b0),
                        1, '{trps_pkg::ST_ADDED, 4'd0}});
        rows.push_back('{mk(trps_pkg::KIND_ADD, 4'd1, 32'hFFFF_FFFF, 8'h00, 32'd7, 32'd7, 1'b0),
                        1, '{trps_pkg::ST_OVERLAP, 4'd0}});
        rows.push_back('{mk(trps_pkg::KIND_LOOKUP, 4'd0, 32'd9, 8'd9, 32'hFFFF_FFFF, 32'd0,
                            1'b0),
                        1, '{trps_pkg::ST_RANGE, 4'd15}});
        rows.push_back('{mk(trps_pkg::KIND_ADD, 4'd2, 32'd0, 8'hFF, 32'd50, 32'd10, 1'b1),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_ADD, 4'd2, 32'd0, 8'hFF, 32'd20, 32'd30, 1'b1),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_ADD, 4'd4, 32'd0, 8'hFF, 32'd100, 32'd200, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_ADD, 4'd5, 32'd0, 8'hFE, 32'd100, 32'd200, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_LOOKUP, 4'd0, 32'd0, 8'hFF, 32'd150, 32'd0, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_LOOKUP, 4'd0, 32'd0, 8'hFF, 32'd25, 32'd0, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_ACTIVE, 4'd2, 32'd0, 8'd0, 32'd0, 32'd0, 1'b1), 1,
                        '{trps_pkg::ST_DONE, 4'd0}});
        rows.push_back('{mk(trps_pkg::KIND_ACTIVE, 4'd9, 32'd0, 8'd0, 32'd0, 32'd0, 1'b1),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_REMOVE, 4'd15, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0), 1,
                        '{trps_pkg::ST_DONE, 4'd0}});
        rows.push_back('{mk(trps_pkg::KIND_LOOKUP, 4'd0, 32'd1, 8'd1, 32'd0, 32'd0, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_LOOKUP, 4'd0, 32'd1, 8'd1, 32'd0, 32'd0, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_ACTIVE, 4'd2, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_LOOKUP, 4'd0, 32'd1, 8'd1, 32'd0, 32'd0, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_REMOVE, 4'd2, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0),
                        0, nil});
        rows.push_back('{mk(trps_pkg::KIND_LOOKUP, 4'd0, 32'd0, 8'hFF, 32'd150, 32'd0, 1'b0),
                        0, nil});
        foreach (rows[i])
            send_cmd(rows[i].cmd, rows[i].fixed, rows[i].res);
        drain();

        // fill the table to report full
        for (int i = 0; i < SLOTS + 2; i++)
            send_cmd(mk(trps_pkg::KIND_ADD, 4'(i), 32'd77, 8'd3, 32'(i * 10),
                        32'(i * 10 + 5), 1'b1),
                     0, nil);
        drain();
        for (int p = 0; p < NPORTS; p++)
            send_cmd(mk(trps_pkg::KIND_REMOVE, 4'(p), 32'd0, 8'd0, 32'd0, 32'd0, 1'b0),
                     0, nil);
        drain();

        n = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin reg_write(3'd0, 32'd100); reg_write(3'd4, 32'd7); end
                1: begin reg_write(3'd0, 32'h0000_0000); reg_write(3'd4, 32'hFF); end
                2: begin reg_write(3'd0, $urandom); reg_write(3'd4, $urandom_range(255)); end
                3: begin reg_write(3'd0, 32'hFFFF_FFFF); reg_write(3'd4, 32'h00); end
                4: begin reg_write(3'd0, 32'd101); reg_write(3'd4, 32'd8); end
                default: begin reg_write(3'd0, 32'd100); reg_write(3'd4, 32'h00); end
            endcase
            quiet = (phase == 3);
            for (int k = 0; k < 325; k++)
            begin
                send_cmd(rand_item($urandom_range(9) != 0), 0, nil);
                n++;
                if (k == 160 && phase == 1)
                    while (status_queue.size() != 0)
                        @(posedge clk);
            end
            quiet = 1'b0;
            drain();
        end

        $display("covered %0d random commands over six wildcard settings, %0d results",
                 n, received);
        $display("range hits %0d, round-robin picks %0d", lookups_by_range, lookups_fallback);
        if (mismatches == 0 && status_queue.size() == 0)
            $display("tid_range_port_selector verification clean");
        else
            $display("tid_range_port_selector verification failed");
        $finish;
    end
endmodule
`default_nettype wire
